// File: src/adsr_pkg.sv
// Shared types and constants for the ADSR envelope generator.
// No dependencies; the configuration registers, the step logic and the top level import this package.
package adsr_pkg;

    // Envelope phase codes
    typedef enum logic [2:0] {
        PH_OFF     = 3'd0,
        PH_ATTACK  = 3'd1,
        PH_DECAY   = 3'd2,
        PH_SUSTAIN = 3'd3,
        PH_RELEASE = 3'd4
    } phase_t;

    // Configuration register map: register index is paddr[4:2]
    localparam int CFG_ADDR_W = 5;
    localparam int CFG_DATA_W = 32;

    typedef logic [2:0] reg_idx_t;

    localparam reg_idx_t REG_ATTACK_STEP    = 3'd0;
    localparam reg_idx_t REG_DECAY_STEP     = 3'd1;
    localparam reg_idx_t REG_SUSTAIN_LEVEL  = 3'd2;
    localparam reg_idx_t REG_RELEASE_STEP   = 3'd3;
    localparam reg_idx_t REG_SMOOTHING_COEF = 3'd4;

endpackage

// File: src/adsr_stream_if.sv
// Valid/ready stream interfaces for the gate input and the level output.
// Depends on nothing; used by the top level of the envelope generator.
interface adsr_in_if ();
    logic valid;
    logic ready;
    logic gate;

    modport source (output valid, output gate, input ready);
    modport sink   (input valid, input gate, output ready);
endinterface

interface adsr_out_if #(
    parameter int LEVEL_W = 24
) ();
    logic               valid;
    logic               ready;
    logic [LEVEL_W-1:0] level;
    logic               is_off;

    modport source (output valid, output level, output is_off, input ready);
    modport sink   (input valid, input level, input is_off, output ready);
endinterface

// File: src/adsr_cfg_regs.sv
// APB-style configuration registers of the envelope generator.
// Depends on adsr_pkg for the register map.
module adsr_cfg_regs #(
    parameter int LEVEL_FRAC_BITS = 23,
    parameter int COEF_FRAC_BITS  = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [adsr_pkg::CFG_ADDR_W-1:0]       paddr,
    input  logic [adsr_pkg::CFG_DATA_W-1:0]       pwdata,
    output logic [adsr_pkg::CFG_DATA_W-1:0]       prdata,
    output logic                                  pready,
    output logic [LEVEL_FRAC_BITS:0]              attack_step,
    output logic [LEVEL_FRAC_BITS:0]              decay_step,
    output logic [LEVEL_FRAC_BITS:0]              sustain_level,
    output logic [LEVEL_FRAC_BITS:0]              release_step,
    output logic [COEF_FRAC_BITS-1:0]             smoothing_coef
);
    import adsr_pkg::*;

    localparam int LW = LEVEL_FRAC_BITS + 1;
    localparam int CW = COEF_FRAC_BITS;
    localparam logic [LW-1:0] FULL_SCALE = {1'b1, {LEVEL_FRAC_BITS{1'b0}}};

    logic [LW-1:0] attack_step_reg,   attack_step_next;
    logic [LW-1:0] decay_step_reg,    decay_step_next;
    logic [LW-1:0] sustain_level_reg, sustain_level_next;
    logic [LW-1:0] release_step_reg,  release_step_next;
    logic [CW-1:0] coef_reg,          coef_next;

    logic     wr_en;
    reg_idx_t idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign idx    = paddr[CFG_ADDR_W-1:2];

    always_comb
    begin
        attack_step_next   = attack_step_reg;
        decay_step_next    = decay_step_reg;
        sustain_level_next = sustain_level_reg;
        release_step_next  = release_step_reg;
        coef_next          = coef_reg;
        if (wr_en)
        begin
            unique case (idx)
                REG_ATTACK_STEP:    attack_step_next   = pwdata[LW-1:0];
                REG_DECAY_STEP:     decay_step_next    = pwdata[LW-1:0];
                REG_SUSTAIN_LEVEL:  sustain_level_next = pwdata[LW-1:0];
                REG_RELEASE_STEP:   release_step_next  = pwdata[LW-1:0];
                REG_SMOOTHING_COEF: coef_next          = pwdata[CW-1:0];
                default:            ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attack_step_reg   <= FULL_SCALE;
            decay_step_reg    <= FULL_SCALE;
            sustain_level_reg <= FULL_SCALE;
            release_step_reg  <= FULL_SCALE;
            coef_reg          <= '0;
        end
        else
        begin
            attack_step_reg   <= attack_step_next;
            decay_step_reg    <= decay_step_next;
            sustain_level_reg <= sustain_level_next;
            release_step_reg  <= release_step_next;
            coef_reg          <= coef_next;
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_ATTACK_STEP:    prdata = CFG_DATA_W'(attack_step_reg);
            REG_DECAY_STEP:     prdata = CFG_DATA_W'(decay_step_reg);
            REG_SUSTAIN_LEVEL:  prdata = CFG_DATA_W'(sustain_level_reg);
            REG_RELEASE_STEP:   prdata = CFG_DATA_W'(release_step_reg);
            REG_SMOOTHING_COEF: prdata = CFG_DATA_W'(coef_reg);
            default:            prdata = '0;
        endcase
    end

    assign attack_step    = attack_step_reg;
    assign decay_step     = decay_step_reg;
    assign sustain_level  = sustain_level_reg;
    assign release_step   = release_step_reg;
    assign smoothing_coef = coef_reg;

endmodule

// File: src/adsr_step.sv
// One-sample envelope update: gate handling, phase transition and new level.
// Depends on adsr_pkg for the phase type.
module adsr_step #(
    parameter int LEVEL_FRAC_BITS = 23,
    parameter int COEF_FRAC_BITS  = 16
) (
    input  logic                      gate,
    input  adsr_pkg::phase_t          cur_phase,
    input  logic [LEVEL_FRAC_BITS:0]  prev_level,
    input  logic [LEVEL_FRAC_BITS:0]  attack_step,
    input  logic [LEVEL_FRAC_BITS:0]  decay_step,
    input  logic [LEVEL_FRAC_BITS:0]  sustain_level,
    input  logic [LEVEL_FRAC_BITS:0]  release_step,
    input  logic [COEF_FRAC_BITS-1:0] smoothing_coef,
    output adsr_pkg::phase_t          next_phase,
    output logic [LEVEL_FRAC_BITS:0]  next_level
);
    import adsr_pkg::*;

    localparam int LW = LEVEL_FRAC_BITS + 1;
    localparam int CW = COEF_FRAC_BITS;
    localparam int PW = LW + CW + 2;
    localparam logic [LW-1:0] FULL_SCALE = {1'b1, {LEVEL_FRAC_BITS{1'b0}}};
    localparam logic signed [PW-1:0] ROUND_HALF =
        {{(LW + 2){1'b0}}, 1'b1, {(CW - 1){1'b0}}};

    phase_t        gated_phase;
    logic [LW-1:0] sus;
    logic [LW:0]   attack_sum;
    logic          attack_full;
    logic [LW-1:0] decay_diff;
    logic          decay_hit;
    logic [LW-1:0] release_diff;
    logic          release_zero;

    logic signed [LW:0]    sus_diff;
    logic signed [CW:0]    coef_s;
    logic signed [PW-1:0]  prod;
    logic signed [PW-1:0]  prod_round;
    logic signed [PW-1:0]  prod_shift;
    logic [LW-1:0]         smooth_level;
    logic [LW-1:0]         level_raw;

    // Apply the gate before the segment update
    always_comb
    begin
        gated_phase = cur_phase;
        if (gate)
        begin
            if (cur_phase == PH_OFF || cur_phase == PH_RELEASE)
                gated_phase = PH_ATTACK;
        end
        else if (cur_phase != PH_OFF)
        begin
            gated_phase = PH_RELEASE;
        end
    end

    assign sus = (sustain_level > FULL_SCALE) ? FULL_SCALE : sustain_level;

    assign attack_sum  = {1'b0, prev_level} + {1'b0, attack_step};
    assign attack_full = attack_sum >= {1'b0, FULL_SCALE};

    assign decay_diff = (prev_level > decay_step) ? prev_level - decay_step : '0;
    assign decay_hit  = decay_diff <= sus;

    assign release_diff = (prev_level > release_step) ? prev_level - release_step : '0;
    assign release_zero = release_diff == '0;

    // sus + round((prev - sus) * c): same as the weighted sum with one multiply
    assign sus_diff     = $signed({1'b0, prev_level}) - $signed({1'b0, sus});
    assign coef_s       = $signed({1'b0, smoothing_coef});
    assign prod         = sus_diff * coef_s;
    assign prod_round   = prod + ROUND_HALF;
    assign prod_shift   = prod_round >>> CW;
    assign smooth_level = sus + prod_shift[LW-1:0];

    always_comb
    begin
        unique case (gated_phase)
            PH_ATTACK:  next_phase = attack_full  ? PH_DECAY   : PH_ATTACK;
            PH_DECAY:   next_phase = decay_hit    ? PH_SUSTAIN : PH_DECAY;
            PH_SUSTAIN: next_phase = PH_SUSTAIN;
            PH_RELEASE: next_phase = release_zero ? PH_OFF     : PH_RELEASE;
            default:    next_phase = PH_OFF;
        endcase
    end

    always_comb
    begin
        unique case (gated_phase)
            PH_ATTACK:  level_raw = attack_full ? FULL_SCALE : attack_sum[LW-1:0];
            PH_DECAY:   level_raw = decay_hit ? sus : decay_diff;
            PH_SUSTAIN: level_raw = smooth_level;
            PH_RELEASE: level_raw = release_diff;
            default:    level_raw = '0;
        endcase
    end

    assign next_level = (level_raw > FULL_SCALE) ? FULL_SCALE : level_raw;

endmodule

// File: src/adsr_envelope_generator.sv
// Top level of the linear ADSR envelope generator: channels, pipeline, state.
// Depends on adsr_pkg, adsr_stream_if, adsr_cfg_regs and adsr_step.
//
//   channel    direction  transfer carries          handshake
//   sample_in  in         gate (1 bit)              valid/ready
//   env_out    out        level (24 b), is_off      valid/ready
//   cfg (APB)  in/out     5 registers, 32-bit data  psel/penable, pready = 1
//
// One gate sample is taken per cycle while the output is not stalled;
// its level is computed from the input register and loaded into the result
// register as the input register moves on. The phase/level feedback runs
// through one multiply in the sustain smoother. An input register and
// a result register part the two sides; a stalled result still lets one
// more sample in. Reset clears phase to off, the level to zero and the
// step registers to full scale (smoothing coefficient to zero).
module adsr_envelope_generator #(
    parameter int LEVEL_FRAC_BITS = 23,
    parameter int COEF_FRAC_BITS  = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    adsr_in_if.sink                         sample_in,
    adsr_out_if.source                      env_out,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [adsr_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [adsr_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [adsr_pkg::CFG_DATA_W-1:0] prdata,
    output logic                            pready
);
    import adsr_pkg::*;

    localparam int LW = LEVEL_FRAC_BITS + 1;
    localparam int CW = COEF_FRAC_BITS;
    localparam logic [LW-1:0] FULL_SCALE = {1'b1, {LEVEL_FRAC_BITS{1'b0}}};

    // Configuration values
    logic [LW-1:0] attack_step;
    logic [LW-1:0] decay_step;
    logic [LW-1:0] sustain_level;
    logic [LW-1:0] release_step;
    logic [CW-1:0] smoothing_coef;

    // Input register
    logic in_valid_reg, in_valid_next;
    logic gate_reg,     gate_next;

    // Result register
    logic          res_valid_reg,  res_valid_next;
    logic [LW-1:0] res_level_reg,  res_level_next;
    logic          res_is_off_reg, res_is_off_next;

    // Envelope state
    phase_t        phase_reg,      phase_next;
    logic [LW-1:0] prev_level_reg, prev_level_next;

    phase_t        step_phase;
    logic [LW-1:0] step_level;
    logic          in_xfer;
    logic          out_xfer;
    logic          advance;

    adsr_cfg_regs #(
        .LEVEL_FRAC_BITS (LEVEL_FRAC_BITS),
        .COEF_FRAC_BITS  (COEF_FRAC_BITS)
    ) u_cfg (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .attack_step    (attack_step),
        .decay_step     (decay_step),
        .sustain_level  (sustain_level),
        .release_step   (release_step),
        .smoothing_coef (smoothing_coef)
    );

    adsr_step #(
        .LEVEL_FRAC_BITS (LEVEL_FRAC_BITS),
        .COEF_FRAC_BITS  (COEF_FRAC_BITS)
    ) u_step (
        .gate           (gate_reg),
        .cur_phase      (phase_reg),
        .prev_level     (prev_level_reg),
        .attack_step    (attack_step),
        .decay_step     (decay_step),
        .sustain_level  (sustain_level),
        .release_step   (release_step),
        .smoothing_coef (smoothing_coef),
        .next_phase     (step_phase),
        .next_level     (step_level)
    );

    // Move the held sample into the result register whenever that register
    // is empty or its transfer completes in this cycle.
    assign out_xfer        = env_out.valid && env_out.ready;
    assign advance         = in_valid_reg && (!res_valid_reg || env_out.ready);
    assign sample_in.ready = !in_valid_reg || advance;
    assign in_xfer         = sample_in.valid && sample_in.ready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        gate_next     = gate_reg;
        if (in_xfer)
        begin
            in_valid_next = 1'b1;
            gate_next     = sample_in.gate;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end
    end

    // The envelope state advances exactly once per sample, together with
    // the result register load.
    always_comb
    begin
        res_valid_next  = res_valid_reg;
        res_level_next  = res_level_reg;
        res_is_off_next = res_is_off_reg;
        phase_next      = phase_reg;
        prev_level_next = prev_level_reg;
        if (advance)
        begin
            res_valid_next  = 1'b1;
            res_level_next  = step_level;
            res_is_off_next = (step_phase == PH_OFF);
            phase_next      = step_phase;
            prev_level_next = step_level;
        end
        else if (out_xfer)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            res_valid_reg  <= 1'b0;
            phase_reg      <= PH_OFF;
            prev_level_reg <= '0;
        end
        else
        begin
            in_valid_reg   <= in_valid_next;
            res_valid_reg  <= res_valid_next;
            phase_reg      <= phase_next;
            prev_level_reg <= prev_level_next;
        end
    end

    // Payload registers: no reset needed
    always_ff @(posedge clk)
    begin
        gate_reg       <= gate_next;
        res_level_reg  <= res_level_next;
        res_is_off_reg <= res_is_off_next;
    end

    assign env_out.valid  = res_valid_reg;
    assign env_out.level  = res_level_reg;
    assign env_out.is_off = res_is_off_reg;

    // The output level never exceeds full scale.
    a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg |-> (res_level_reg <= FULL_SCALE))
        else $error("envelope level above full scale");

    // Off means a silent sample.
    a_off_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && res_is_off_reg) |-> (res_level_reg == '0))
        else $error("off phase with nonzero level");

    // A held gate never lands in off.
    a_gate_not_off: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && gate_reg) |=> (!res_is_off_reg && phase_reg != PH_OFF))
        else $error("gate high produced off phase");

    // A low gate while off stays off at zero level.
    a_stay_off: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && !gate_reg && phase_reg == PH_OFF)
        |=> (phase_reg == PH_OFF && prev_level_reg == '0))
        else $error("left off phase without a gate");

    // The state and the result register only move together.
    a_state_tracks_result: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && !advance) |=> $stable(prev_level_reg))
        else $error("envelope state moved without a result load");

endmodule
